@@ rtl/mgsa_pkg.sv @@
package mgsa_pkg;

    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic [COUNT_W-1:0]  SLOT_COUNT_RESET = 7'd64;

    localparam logic                MODE_ALLOC       = 1'b0;
    localparam logic                MODE_RELEASE     = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_HELD  = 2'd2;

    typedef struct packed {
        logic              mode;
        logic [SLOT_W-1:0] slot_index;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   chosen_slot;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_REL_RD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic sample;
    } scan_ctl_t;

endpackage

@@ rtl/mgsa_ram.sv @@
module mgsa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/mgsa_gap.sv @@
module mgsa_gap #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mgsa_pkg::scan_ctl_t            ctl,
    input  logic [$clog2(MAX_SLOTS)-1:0]   sample_idx,
    input  logic                           sample_occ,
    input  logic [$clog2(MAX_SLOTS+1)-1:0] n,
    output logic                           found,
    output logic [$clog2(MAX_SLOTS)-1:0]   pick
);

    import mgsa_pkg::*;

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);

    logic          seen_reg,  seen_next;
    logic          found_reg, found_next;
    logic [IW-1:0] prev_reg,  prev_next;
    logic [IW-1:0] best_reg,  best_next;
    logic [IW-1:0] bestd_reg, bestd_next;

    logic [IW:0]   gap_sum;
    logic [IW-1:0] gap_mid;
    logic [IW-1:0] gap_d;
    logic [IW-1:0] last_idx;
    logic [IW-1:0] end_d;

    always_comb
    begin
        gap_sum = (IW+1)'(prev_reg) + (IW+1)'(sample_idx);
        gap_mid = gap_sum[IW:1];
        gap_d   = gap_mid - prev_reg;

        seen_next  = seen_reg;
        found_next = found_reg;
        prev_next  = prev_reg;
        best_next  = best_reg;
        bestd_next = bestd_reg;

        if (ctl.start)
        begin
            seen_next  = 1'b0;
            found_next = 1'b0;
        end
        else if (ctl.sample && sample_occ)
        begin
            if (!seen_reg)
            begin
                // Slot 0 is free: its distance is the first occupied index.
                if (sample_idx != '0)
                begin
                    best_next  = '0;
                    bestd_next = sample_idx;
                    found_next = 1'b1;
                end
                seen_next = 1'b1;
            end
            else if ((IW+1)'(sample_idx) > (IW+1)'(prev_reg) + (IW+1)'(1))
            begin
                if (!found_reg || gap_d > bestd_reg)
                begin
                    best_next  = gap_mid;
                    bestd_next = gap_d;
                    found_next = 1'b1;
                end
            end
            prev_next = sample_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            seen_reg  <= seen_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg  <= prev_next;
        best_reg  <= best_next;
        bestd_reg <= bestd_next;
    end

    // The far end of the row is weighed once the sweep has finished.
    always_comb
    begin
        last_idx = IW'(n - CW'(1));
        end_d    = last_idx - prev_reg;
        if (!seen_reg)
        begin
            found = 1'b1;
            pick  = '0;
        end
        else if (prev_reg < last_idx && (!found_reg || end_d > bestd_reg))
        begin
            found = 1'b1;
            pick  = last_idx;
        end
        else
        begin
            found = found_reg;
            pick  = best_reg;
        end
    end

endmodule

@@ rtl/max_gap_slot_allocator.sv @@
// Keeps one occupancy bit per slot in a single-port-read RAM and serves allocate
// and release words. An allocate sweeps the first n slots, one RAM read per cycle,
// where n is slot_count clamped to 1..MAX_SLOTS, then marks the slot it chose; a
// release reads one entry and then clears it if it was held and lies in the row.
// After reset the block clears every entry of the RAM and takes no
// request words during that time; configuration writes are taken at any time.
// A finished result sits in an output register, so the next word is taken while
// the previous result still waits.
module max_gap_slot_allocator #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mgsa_pkg::COUNT_W-1:0]    cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  mgsa_pkg::req_t                  in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output mgsa_pkg::rsp_t                  out_data
);

    import mgsa_pkg::*;

    localparam int IW   = $clog2(MAX_SLOTS);
    localparam int CW   = $clog2(MAX_SLOTS + 1);
    localparam int NW   = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0] slot_count_reg;
    logic [CW-1:0]      n_reg, n_next;
    req_t               req_reg;
    logic [CW-1:0]      addr_reg, addr_next;
    logic               pend_vld_reg, pend_vld_next;
    logic [IW-1:0]      pend_idx_reg;
    logic               out_valid_reg;
    rsp_t               out_data_reg;

    logic               accept;
    logic               ram_wr_en;
    logic [IW-1:0]      ram_wr_addr;
    logic [0:0]         ram_wr_data;
    logic               ram_rd_en;
    logic [IW-1:0]      ram_rd_addr;
    logic [0:0]         ram_rd_data;

    scan_ctl_t          gap_ctl;
    logic               gap_found;
    logic [IW-1:0]      gap_pick;

    logic               out_free;
    logic               out_load;
    rsp_t               rsp;
    logic               rel_ok;
    logic [NW-1:0]      count_ext;

    mgsa_ram #(
        .WIDTH (1),
        .DEPTH (MAX_SLOTS)
    ) u_occ_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    mgsa_gap #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_gap (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (gap_ctl),
        .sample_idx (pend_idx_reg),
        .sample_occ (ram_rd_data[0]),
        .n          (n_reg),
        .found      (gap_found),
        .pick       (gap_pick)
    );

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    // Clamp the configured count into 1..MAX_SLOTS.
    always_comb
    begin
        count_ext = NW'(slot_count_reg);
        if (count_ext == '0)
        begin
            n_next = CW'(1);
        end
        else if (count_ext > NW'(MAX_SLOTS))
        begin
            n_next = CW'(MAX_SLOTS);
        end
        else
        begin
            n_next = CW'(count_ext);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (addr_reg == CW'(MAX_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_data.mode == MODE_ALLOC) ? ST_SCAN : ST_REL_RD;
                end
            end
            ST_SCAN:
            begin
                if (addr_reg == n_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_REL_RD:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = addr_reg[IW-1:0];
        ram_wr_en     = 1'b0;
        ram_wr_addr   = addr_reg[IW-1:0];
        ram_wr_data   = 1'b0;
        gap_ctl       = '0;
        out_load      = 1'b0;
        pend_vld_next = 1'b0;
        addr_next     = addr_reg;
        rel_ok        = (CMPW'(req_reg.slot_index) < CMPW'(n_reg)) && ram_rd_data[0];
        rsp           = '0;

        if (req_reg.mode == MODE_ALLOC)
        begin
            rsp.chosen_slot = gap_found ? SLOT_W'(gap_pick) : '0;
            rsp.status      = gap_found ? STATUS_DONE : STATUS_FULL;
        end
        else
        begin
            rsp.chosen_slot = req_reg.slot_index;
            rsp.status      = rel_ok ? STATUS_DONE : STATUS_NOT_HELD;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en = 1'b1;
                addr_next = addr_reg + CW'(1);
            end
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                gap_ctl.start = 1'b1;
                addr_next     = '0;
            end
            ST_SCAN:
            begin
                gap_ctl.sample = pend_vld_reg;
                if (addr_reg < n_reg)
                begin
                    ram_rd_en     = 1'b1;
                    pend_vld_next = 1'b1;
                    addr_next     = addr_reg + CW'(1);
                end
            end
            ST_REL_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = IW'(req_reg.slot_index);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (req_reg.mode == MODE_ALLOC)
                    begin
                        ram_wr_en   = gap_found;
                        ram_wr_addr = gap_pick;
                        ram_wr_data = 1'b1;
                    end
                    else
                    begin
                        ram_wr_en   = rel_ok;
                        ram_wr_addr = IW'(req_reg.slot_index);
                        ram_wr_data = 1'b0;
                    end
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            slot_count_reg <= SLOT_COUNT_RESET;
            addr_reg       <= '0;
            pend_vld_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            pend_vld_reg <= pend_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                slot_count_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= addr_reg[IW-1:0];
        if (accept)
        begin
            req_reg <= in_data;
            n_reg   <= n_next;
        end
        if (out_load)
        begin
            out_data_reg <= rsp;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == ST_CLEAR || state_reg == ST_DONE))
        else $error("occupancy RAM written outside clearing or completion");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !in_ready)
        else $error("request word taken during clearing pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && req_reg.mode == MODE_ALLOC && gap_found)
            |-> (CW'(gap_pick) < n_reg))
        else $error("allocated slot lies beyond the row");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.status == STATUS_DONE
                           || out_data_reg.status == STATUS_FULL
                           || out_data_reg.status == STATUS_NOT_HELD))
        else $error("result word carries an undefined status");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && addr_reg == n_reg) |-> pend_vld_reg)
        else $error("sweep ended without the last slot in flight");

endmodule
